@@ src/ptab_pkg.sv @@
// ptab_pkg: request, response and piece types plus command and status codes
// for the piece table editor; no dependencies
package ptab_pkg;

	typedef enum logic [1:0] {
		CMD_RESET  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] pos;
		logic        source;
		logic [31:0] source_offset;
		logic [31:0] amount;
		logic [6:0]  piece_index;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [31:0] doc_length;
		logic [6:0]  piece_count;
		logic        read_source;
		logic [31:0] read_offset;
		logic [31:0] read_length;
	} rsp_t;

	typedef struct packed {
		logic        src;
		logic [31:0] off;
		logic [31:0] len;
	} piece_t;

endpackage

@@ src/ptab_stream_if.sv @@
// ptab_stream_if: valid/ready channel carrying one payload type
// payload type comes from ptab_pkg at the point of instantiation
interface ptab_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/piece_table_editor_top.sv @@
// piece_table_editor_top: piece table editor, sequencer plus piece store
// depends on ptab_pkg, ptab_stream_if and ptab_ram
//
// Usage: requests arrive on req (ptab_stream_if of req_t) and each request
// gives exactly one response on rsp (ptab_stream_if of rsp_t), in order.
// Commands are reset (empty or one piece), insert, remove and read piece.
// The block takes one request at a time: req.ready is high only while the
// sequencer waits for work. Every request is walked by one sequencer that
// drives one shared add/compare path and the piece ram (one write port, one read port).
// Paths: reset, zero-length insert, null remove and out-of-range read go
// straight to the response; read fetches the piece; insert on the typing hint
// extends the hinted piece; insert scans up to the target piece, moves the
// pieces behind it up into open slots, then writes the new pieces; append
// at the end writes one piece after the scan; remove does the same scan,
// then per piece touched moves later pieces down (up for a split) and
// writes what is left of that piece.
// The scan reads each piece through the ram's registered read port, in a
// read state and a check state; moves are one read plus one write per piece.
// A finished response sits in an output register; a new request can be
// accepted while it waits, but the next response holds until rsp.ready.
// Reset (arst_n low) empties the table and clears the hint; the ram itself
// is not cleared, entries past the piece count are never read.
module piece_table_editor_top import ptab_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int SLOT_COUNT  = 65
) (
	input  logic          clk,
	input  logic          arst_n,
	ptab_stream_if.sink   req,
	ptab_stream_if.source rsp
);
	localparam int AW   = $clog2(SLOT_COUNT);
	localparam int CW   = $clog2(SLOT_COUNT + 1);
	localparam int CMPW = $clog2((MAX_ENTRIES > SLOT_COUNT ? MAX_ENTRIES : SLOT_COUNT) + 3);
	localparam logic [CMPW-1:0] MAX_W  = CMPW'(MAX_ENTRIES);
	localparam logic [CMPW-1:0] SLOT_W = CMPW'(SLOT_COUNT);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_HINT    = 11'b00000000010,
		S_SCAN_RD = 11'b00000000100,
		S_SCAN_CK = 11'b00000001000,
		S_ACT     = 11'b00000010000,
		S_MOVE_RD = 11'b00000100000,
		S_MOVE_WR = 11'b00001000000,
		S_FILL    = 11'b00010000000,
		S_READ    = 11'b00100000000,
		S_FIN     = 11'b01000000000,
		S_DONE    = 11'b10000000000
	} state_t;

	state_t          state_q;
	// table state
	logic [CW-1:0]   used_q;
	logic [31:0]     total_q;
	logic            hint_valid_q;
	logic [AW-1:0]   hint_slot_q;
	logic [31:0]     hint_end_q;
	// request working registers
	cmd_t            cmd_q;
	logic [31:0]     p_q;
	logic            s_q;
	logic [31:0]     so_q;
	logic [31:0]     n_q;
	logic [CW-1:0]   k_q;
	logic [31:0]     start_q;
	logic [31:0]     within_q;
	piece_t          ent_q;
	logic            status_q;
	piece_t          rd_q;
	logic            cont_q;
	// move and fill sequencing
	logic [CW-1:0]   src_j_q;
	logic [CW-1:0]   mv_last_q;
	logic            mv_up_q;
	logic [1:0]      mv_dist_q;
	piece_t          fill_q [3];
	logic [1:0]      fill_n_q;
	logic [1:0]      fill_i_q;
	logic [CW-1:0]   fb_q;
	// response register
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	// ram port
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	piece_t          ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [$bits(piece_t)-1:0] ram_rdata;
	piece_t          rdata;

	ptab_ram #(
		.WIDTH($bits(piece_t)),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rdata = piece_t'(ram_rdata);

	logic accept;
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// response register loads once the previous response is gone or leaving
	logic rsp_load;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// request decode on accept
	logic [31:0]   room, in_n, in_p, rm_n;
	logic          fast_ok;
	logic [CMPW-1:0] uw;

	always_comb begin
		room    = ~total_q;
		in_n    = (req.data.amount > room) ? room : req.data.amount;
		in_p    = (req.data.pos > total_q) ? total_q : req.data.pos;
		rm_n    = (req.data.amount > total_q - req.data.pos) ?
			(total_q - req.data.pos) : req.data.amount;
		fast_ok = hint_valid_q && (in_p == hint_end_q) && req.data.source &&
			(CW'(hint_slot_q) < used_q);
		uw      = CMPW'(used_q);
	end

	// hint match: piece end computed without wrap
	logic hint_hit;
	assign hint_hit = ({1'b0, rdata.off} + {1'b0, rdata.len}) == {1'b0, so_q};

	// scan step
	logic [31:0] stop;
	assign stop = start_q + rdata.len;

	// action decode on the located piece
	logic          wz, ins, ins_fail, rm_drop, rm_front, rm_tail, rm_split, rm_fail;
	logic [31:0]   avail, take, left_nx;
	logic [CW-1:0] lo, used_d, k_next;
	logic          mv_up_c, mv_need;
	logic [1:0]    mv_dist_c, fill_n_c;
	piece_t        f0, f1, f2, keep, fresh;

	always_comb begin
		ins      = (cmd_q == CMD_INSERT);
		wz       = (within_q == 32'd0);
		avail    = ent_q.len - within_q;
		take     = (n_q < avail) ? n_q : avail;
		left_nx  = n_q - take;
		rm_drop  = wz && (take == ent_q.len);
		rm_front = wz && !rm_drop;
		rm_tail  = !wz && (take == avail);
		rm_split = !wz && !rm_tail;
		ins_fail = wz ? (uw >= MAX_W || uw + 1'b1 > SLOT_W) :
			(uw + 2'd2 > MAX_W || uw + 2'd2 > SLOT_W);
		rm_fail  = rm_split && (uw + 1'b1 > SLOT_W);
		lo       = (ins && wz) ? k_q : k_q + 1'b1;
		keep     = '{src: ent_q.src, off: ent_q.off, len: within_q};
		fresh    = '{src: s_q, off: so_q, len: n_q};
		f0       = keep;
		f1       = fresh;
		f2       = '{src: ent_q.src, off: ent_q.off + within_q, len: avail};
		k_next   = k_q;
		if (ins) begin
			mv_up_c   = 1'b1;
			mv_dist_c = wz ? 2'd1 : 2'd2;
			mv_need   = lo < used_q;
			used_d    = used_q + (wz ? CW'(1) : CW'(2));
			fill_n_c  = wz ? 2'd1 : 2'd3;
			if (wz) begin
				f0 = fresh;
			end
		end else begin
			mv_up_c   = !rm_drop;
			mv_dist_c = 2'd1;
			mv_need   = (rm_drop || rm_split) && (lo < used_q);
			used_d    = rm_drop ? used_q - 1'b1 : (rm_split ? used_q + 1'b1 : used_q);
			fill_n_c  = rm_drop ? 2'd0 : (rm_split ? 2'd2 : 2'd1);
			if (rm_front) begin
				f0 = '{src: ent_q.src, off: ent_q.off + take, len: ent_q.len - take};
			end
			// right part of a split keeps the text past the removed span
			f1 = '{src: ent_q.src, off: ent_q.off + within_q + take,
				len: avail - take};
			if (rm_tail) begin
				k_next = k_q + 1'b1;
			end
		end
	end

	// ram address and write control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = (req.data.cmd == CMD_READ) ? AW'(req.data.piece_index) : hint_slot_q;
				if (accept && req.data.cmd == CMD_RESET && req.data.amount != 32'd0) begin
					ram_we    = 1'b1;
					ram_wdata = '{src: req.data.source, off: 32'd0, len: req.data.amount};
				end
			end
			S_HINT: begin
				if (hint_hit) begin
					ram_we    = 1'b1;
					ram_waddr = hint_slot_q;
					ram_wdata = '{src: rdata.src, off: rdata.off, len: rdata.len + n_q};
				end
			end
			S_SCAN_RD: begin
				ram_raddr = AW'(k_q);
				// append at the document end
				if (k_q == used_q && ins && uw < MAX_W && uw < SLOT_W) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(used_q);
					ram_wdata = fresh;
				end
			end
			S_MOVE_RD: begin
				ram_raddr = AW'(src_j_q);
			end
			S_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = mv_up_q ? AW'(src_j_q + CW'(mv_dist_q)) : AW'(src_j_q - 1'b1);
				ram_wdata = rdata;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(fb_q + CW'(fill_i_q));
				ram_wdata = fill_q[fill_i_q];
			end
			S_SCAN_CK, S_ACT, S_READ, S_FIN, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			total_q      <= '0;
			hint_valid_q <= 1'b0;
			hint_slot_q  <= '0;
			hint_end_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			cmd_q        <= CMD_RESET;
			p_q          <= '0;
			s_q          <= 1'b0;
			so_q         <= '0;
			n_q          <= '0;
			k_q          <= '0;
			start_q      <= '0;
			within_q     <= '0;
			ent_q        <= '0;
			status_q     <= STATUS_OK;
			rd_q         <= '0;
			cont_q       <= 1'b0;
			src_j_q      <= '0;
			mv_last_q    <= '0;
			mv_up_q      <= 1'b0;
			mv_dist_q    <= '0;
			fill_q       <= '{default: '0};
			fill_n_q     <= '0;
			fill_i_q     <= '0;
			fb_q         <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= req.data.cmd;
						s_q      <= req.data.source;
						so_q     <= req.data.source_offset;
						status_q <= STATUS_OK;
						rd_q     <= '0;
						k_q      <= '0;
						start_q  <= '0;
						unique case (req.data.cmd)
							CMD_RESET: begin
								used_q       <= (req.data.amount != 32'd0) ? CW'(1) : CW'(0);
								total_q      <= req.data.amount;
								hint_valid_q <= 1'b0;
								state_q      <= S_DONE;
							end
							CMD_INSERT: begin
								n_q <= in_n;
								p_q <= in_p;
								if (in_n == 32'd0) begin
									state_q <= S_DONE;
								end else if (fast_ok) begin
									state_q <= S_HINT;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							CMD_REMOVE: begin
								hint_valid_q <= 1'b0;
								p_q          <= req.data.pos;
								n_q          <= rm_n;
								if (req.data.amount == 32'd0 || req.data.pos >= total_q) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							CMD_READ: begin
								if (32'(req.data.piece_index) < 32'(used_q)) begin
									state_q <= S_READ;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_HINT: begin
					if (hint_hit) begin
						total_q    <= total_q + n_q;
						hint_end_q <= hint_end_q + n_q;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (k_q == used_q) begin
						// position at the document end
						if (ins) begin
							if (uw >= MAX_W || uw >= SLOT_W) begin
								status_q <= STATUS_FULL;
							end else begin
								hint_valid_q <= s_q;
								if (s_q) begin
									hint_slot_q <= AW'(used_q);
									hint_end_q  <= total_q + n_q;
								end
								used_q  <= used_q + 1'b1;
								total_q <= total_q + n_q;
							end
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_CK;
					end
				end
				S_SCAN_CK: begin
					if (p_q < stop) begin
						within_q <= p_q - start_q;
						ent_q    <= rdata;
						state_q  <= S_ACT;
					end else begin
						start_q <= stop;
						k_q     <= k_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_ACT: begin
					if (ins && ins_fail) begin
						status_q <= STATUS_FULL;
						state_q  <= S_DONE;
					end else if (!ins && rm_fail) begin
						state_q <= S_DONE;
					end else begin
						used_q    <= used_d;
						fill_q    <= '{f0, f1, f2};
						fill_n_q  <= fill_n_c;
						fill_i_q  <= '0;
						fb_q      <= k_q;
						mv_up_q   <= mv_up_c;
						mv_dist_q <= mv_dist_c;
						src_j_q   <= mv_up_c ? used_q - 1'b1 : lo;
						mv_last_q <= mv_up_c ? lo : used_q - 1'b1;
						if (ins) begin
							total_q      <= total_q + n_q;
							hint_valid_q <= 1'b0;
							cont_q       <= 1'b0;
						end else begin
							total_q <= total_q - take;
							n_q     <= left_nx;
							cont_q  <= (left_nx != 32'd0);
							k_q     <= k_next;
							start_q <= p_q;
						end
						if (mv_need) begin
							state_q <= S_MOVE_RD;
						end else if (fill_n_c != 2'd0) begin
							state_q <= S_FILL;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					if (src_j_q == mv_last_q) begin
						state_q <= (fill_n_q != 2'd0) ? S_FILL : S_FIN;
					end else begin
						src_j_q <= mv_up_q ? src_j_q - 1'b1 : src_j_q + 1'b1;
						state_q <= S_MOVE_RD;
					end
				end
				S_FILL: begin
					fill_i_q <= fill_i_q + 1'b1;
					if (fill_i_q == fill_n_q - 1'b1) begin
						state_q <= S_FIN;
					end
				end
				S_READ: begin
					rd_q    <= rdata;
					state_q <= S_DONE;
				end
				S_FIN: begin
					state_q <= cont_q ? S_SCAN_RD : S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.status      <= status_q;
						rsp_q.doc_length  <= total_q;
						rsp_q.piece_count <= 7'(used_q);
						rsp_q.read_source <= rd_q.src;
						rsp_q.read_offset <= rd_q.off;
						rsp_q.read_length <= rd_q.len;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// piece count never passes the store size
	assert property (@(posedge clk) disable iff (!arst_n) CMPW'(used_q) <= SLOT_W)
		else $error("piece count beyond store");

	// the typing hint always names a live piece
	assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid_q |-> (CW'(hint_slot_q) < used_q))
		else $error("hint names a slot past the piece count");

	// fill writes stay inside the store
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (CMPW'(fb_q) + CMPW'(fill_i_q) < SLOT_W))
		else $error("fill write outside store");

	// a move or fill sequence only runs for insert or remove
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE_WR || state_q == S_FILL) |->
		(cmd_q == CMD_INSERT || cmd_q == CMD_REMOVE))
		else $error("store rewrite outside an edit");

endmodule

@@ src/ptab_ram.sv @@
// ptab_ram: generic single write port, single read port ram with registered read
// no dependencies
module ptab_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ tb/ptab_tb_pkg.sv @@
`timescale 1ns / 1ps
// ptab_tb_pkg: piece table predictor used by the testbench top
// depends on ptab_pkg for request, response and command types
package ptab_tb_pkg;
	import ptab_pkg::*;

	localparam int TABLE_LIMIT = 64;
	localparam int STORE_DEPTH = 65;

	logic        pc_src [STORE_DEPTH];
	logic [31:0] pc_off [STORE_DEPTH];
	logic [31:0] pc_len [STORE_DEPTH];
	int unsigned n_pieces;
	logic [31:0] doc_chars;
	logic        typing_valid;
	int unsigned typing_slot;
	logic [31:0] typing_end;

	function automatic void table_clear();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			pc_src[i] = 0;
			pc_off[i] = 0;
			pc_len[i] = 0;
		end
		n_pieces = 0;
		doc_chars = 0;
		typing_valid = 0;
		typing_slot = 0;
		typing_end = 0;
	endfunction

	// piece holding position p, n_pieces when at or past the end
	function automatic int unsigned locate(logic [31:0] p, output logic [31:0] inner);
		logic [31:0] start;
		logic [31:0] stop;
		start = 0;
		for (int unsigned k = 0; k < n_pieces; k++) begin
			stop = start + pc_len[k];
			if (p < stop) begin
				inner = p - start;
				return k;
			end
			start = stop;
		end
		inner = 0;
		return n_pieces;
	endfunction

	function automatic bit shift_up(int unsigned at, int unsigned n);
		if (at > n_pieces || n_pieces + n > STORE_DEPTH)
			return 0;
		for (int i = int'(n_pieces) - 1; i >= int'(at); i--) begin
			pc_src[i + n] = pc_src[i];
			pc_off[i + n] = pc_off[i];
			pc_len[i + n] = pc_len[i];
		end
		n_pieces += n;
		return 1;
	endfunction

	function automatic void shift_down(int unsigned at);
		if (at >= n_pieces)
			return;
		for (int unsigned i = at; i + 1 < n_pieces; i++) begin
			pc_src[i] = pc_src[i + 1];
			pc_off[i] = pc_off[i + 1];
			pc_len[i] = pc_len[i + 1];
		end
		n_pieces -= 1;
	endfunction

	function automatic logic insert_text(logic [31:0] p, logic s, logic [31:0] so,
			logic [31:0] n);
		logic [31:0] room;
		logic [31:0] inner;
		logic [32:0] tail;
		int unsigned k;
		logic        os;
		logic [31:0] oo;
		logic [31:0] ol;
		room = 32'hFFFF_FFFF - doc_chars;
		if (n > room)
			n = room;
		if (n == 0)
			return STATUS_OK;
		if (p > doc_chars)
			p = doc_chars;
		if (typing_valid && p == typing_end && s && typing_slot < n_pieces) begin
			tail = {1'b0, pc_off[typing_slot]} + {1'b0, pc_len[typing_slot]};
			if (tail == {1'b0, so}) begin
				pc_len[typing_slot] += n;
				doc_chars += n;
				typing_end += n;
				return STATUS_OK;
			end
		end
		k = locate(p, inner);
		if (k == n_pieces) begin
			if (n_pieces >= TABLE_LIMIT)
				return STATUS_FULL;
			pc_src[k] = s;
			pc_off[k] = so;
			pc_len[k] = n;
			typing_valid = s;
			if (s) begin
				typing_slot = k;
				typing_end = doc_chars + n;
			end
			n_pieces += 1;
			doc_chars += n;
			return STATUS_OK;
		end
		if (inner == 0) begin
			if (n_pieces >= TABLE_LIMIT || !shift_up(k, 1))
				return STATUS_FULL;
			pc_src[k] = s;
			pc_off[k] = so;
			pc_len[k] = n;
		end else begin
			if (n_pieces + 2 > TABLE_LIMIT)
				return STATUS_FULL;
			os = pc_src[k];
			oo = pc_off[k];
			ol = pc_len[k];
			if (!shift_up(k + 1, 2))
				return STATUS_FULL;
			pc_len[k] = inner;
			pc_src[k + 1] = s;
			pc_off[k + 1] = so;
			pc_len[k + 1] = n;
			pc_src[k + 2] = os;
			pc_off[k + 2] = oo + inner;
			pc_len[k + 2] = ol - inner;
		end
		typing_valid = 0;
		doc_chars += n;
		return STATUS_OK;
	endfunction

	function automatic void remove_text(logic [31:0] p, logic [31:0] n);
		logic [31:0] left;
		logic [31:0] inner;
		logic [31:0] len;
		logic [31:0] avail;
		logic [31:0] take;
		logic        os;
		logic [31:0] oo;
		int unsigned k;
		typing_valid = 0;
		if (n == 0 || p >= doc_chars)
			return;
		if (n > doc_chars - p)
			n = doc_chars - p;
		left = n;
		for (int g = 0; left > 0 && g < STORE_DEPTH + 2; g++) begin
			k = locate(p, inner);
			if (k >= n_pieces)
				break;
			len = pc_len[k];
			avail = len - inner;
			take = left < avail ? left : avail;
			if (inner == 0 && take == len) begin
				shift_down(k);
			end else if (inner == 0) begin
				pc_off[k] += take;
				pc_len[k] -= take;
			end else if (take == avail) begin
				pc_len[k] = inner;
			end else begin
				os = pc_src[k];
				oo = pc_off[k];
				if (!shift_up(k + 1, 1))
					break;
				pc_len[k] = inner;
				pc_src[k + 1] = os;
				pc_off[k + 1] = oo + inner + take;
				pc_len[k + 1] = len - inner - take;
			end
			doc_chars -= take;
			left -= take;
		end
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		o = '0;
		case (r.cmd)
			CMD_RESET: begin
				n_pieces = 0;
				doc_chars = 0;
				typing_valid = 0;
				if (r.amount > 0) begin
					pc_src[0] = r.source;
					pc_off[0] = 0;
					pc_len[0] = r.amount;
					n_pieces = 1;
					doc_chars = r.amount;
				end
			end
			CMD_INSERT: o.status = insert_text(r.pos, r.source, r.source_offset, r.amount);
			CMD_REMOVE: remove_text(r.pos, r.amount);
			default: begin
				if (r.piece_index < n_pieces) begin
					o.read_source = pc_src[r.piece_index];
					o.read_offset = pc_off[r.piece_index];
					o.read_length = pc_len[r.piece_index];
				end
			end
		endcase
		o.doc_length = doc_chars;
		o.piece_count = n_pieces[6:0];
		return o;
	endfunction
endpackage

@@ tb/piece_table_editor_top_tb.sv @@
`timescale 1ns / 1ps
// piece_table_editor_top_tb: self-checking bench for the piece table editor
// depends on ptab_pkg, ptab_stream_if, ptab_tb_pkg and the editor rtl
module piece_table_editor_top_tb;
	import ptab_pkg::*;
	import ptab_tb_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;

	logic clk;
	logic arst_n;

	ptab_stream_if #(.payload_t(req_t)) req_ch ();
	ptab_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	piece_table_editor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// pending requests from the stimulus, expected responses for the checker
	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   mismatch_count;
	int   cycle_count;
	bit   stimulus_done;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// request driver: random gap before each request, held until accepted
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			send_gap <= $urandom_range(0, 17);
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				// accepted: model predicts right here, in accept order
				expected_rsps.push_back(apply_request(req_ch.data));
				req_ch.valid <= 1'b0;
				send_gap <= $urandom_range(0, 17);
			end else if (!req_ch.valid) begin
				if (send_gap > 0)
					send_gap <= send_gap - 1;
				else if (pending_reqs.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_reqs.pop_front();
				end
			end
		end
	end

	// response monitor: random stalls on ready, compare on accept
	int recv_gap;
	rsp_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap <= $urandom_range(0, 17);
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected response %p", rsp_ch.data);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.data !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("response mismatch: expected %p got %p", want, rsp_ch.data);
					end
				end
				rsp_ch.ready <= 1'b0;
				recv_gap <= $urandom_range(0, 17);
			end else if (!rsp_ch.ready) begin
				if (recv_gap > 0)
					recv_gap <= recv_gap - 1;
				else
					rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("piece_table_editor_top verification failed");
			$finish;
		end
	end

	function automatic req_t mk(cmd_t c, logic [31:0] p, logic s, logic [31:0] so,
			logic [31:0] a, logic [6:0] idx);
		req_t r;
		r.cmd = c;
		r.pos = p;
		r.source = s;
		r.source_offset = so;
		r.amount = a;
		r.piece_index = idx;
		return r;
	endfunction

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 40);
			1: return $urandom_range(0, 400);
			2: return $urandom;
			default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
	endfunction

	initial begin
		logic [31:0] type_pos;
		logic [31:0] type_off;
		req_t        r;
		int          n;
		arst_n = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		stimulus_done = 0;
		table_clear();
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reads on the empty table, resets, typing, splits, overflow
		pending_reqs.push_back(mk(CMD_READ, 0, 0, 0, 0, 7'd0));
		pending_reqs.push_back(mk(CMD_REMOVE, 0, 0, 0, 5, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 0, 1, 0, 0, 0));
		pending_reqs.push_back(mk(CMD_RESET, 0, 0, 32'hFFFF_FFFF, 100, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 32'hFFFF_FFFF, 1, 10, 5, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 105, 1, 15, 3, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 50, 0, 32'hFFFF_FFF0, 20, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 0, 1, 7, 4, 0));
		pending_reqs.push_back(mk(CMD_READ, 0, 0, 0, 0, 7'd2));
		pending_reqs.push_back(mk(CMD_READ, 0, 0, 0, 0, 7'd64));
		pending_reqs.push_back(mk(CMD_READ, 0, 0, 0, 0, 7'd127));
		pending_reqs.push_back(mk(CMD_REMOVE, 60, 0, 0, 2, 0));
		pending_reqs.push_back(mk(CMD_REMOVE, 10, 0, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(CMD_REMOVE, 32'hFFFF_FFFF, 0, 0, 1, 0));
		pending_reqs.push_back(mk(CMD_RESET, 0, 1, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 3, 1, 32'hFFFF_FFFF, 9, 0));
		pending_reqs.push_back(mk(CMD_READ, 0, 0, 0, 0, 7'd0));
		pending_reqs.push_back(mk(CMD_RESET, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 0, 1, 32'hFFFF_FFFF, 1, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 1, 1, 0, 1, 0));
		// table fill until refused: splits of a single big piece
		pending_reqs.push_back(mk(CMD_RESET, 0, 0, 0, 1000, 0));
		for (int i = 0; i < 40; i++)
			pending_reqs.push_back(mk(CMD_INSERT, 1 + i * 7, 0, i, 1, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 0, 1, 0, 1, 0));
		pending_reqs.push_back(mk(CMD_INSERT, 2000, 1, 0, 1, 0));
		pending_reqs.push_back(mk(CMD_REMOVE, 3, 0, 0, 100, 0));
		pending_reqs.push_back(mk(CMD_READ, 0, 0, 0, 0, 7'd1));

		// random: mostly typing bursts and edits on a small document
		n = 0;
		type_pos = 0;
		type_off = 0;
		while (n < 485) begin
			case ($urandom_range(0, 9))
				0: begin
					r = mk(CMD_RESET, rnd_word(), $urandom_range(0, 1), rnd_word(),
						$urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 300),
						$urandom);
					pending_reqs.push_back(r);
					n++;
				end
				1, 2, 3: begin
					// typing burst: contiguous edit-buffer inserts
					type_pos = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 300);
					type_off = rnd_word();
					repeat ($urandom_range(1, 6)) begin
						r = mk(CMD_INSERT, type_pos, 1, type_off, $urandom_range(1, 5), $urandom);
						if ($urandom_range(0, 7) == 0)
							r.source_offset = rnd_word();
						pending_reqs.push_back(r);
						type_pos += r.amount;
						type_off = r.source_offset + r.amount;
						n++;
					end
				end
				4, 5: begin
					pending_reqs.push_back(mk(CMD_INSERT,
						$urandom_range(0, 1) ? $urandom_range(0, 400) : rnd_word(),
						$urandom_range(0, 1), rnd_word(),
						$urandom_range(0, 5) == 0 ? rnd_word() : $urandom_range(0, 20),
						$urandom));
					n++;
				end
				6, 7: begin
					pending_reqs.push_back(mk(CMD_REMOVE,
						$urandom_range(0, 1) ? $urandom_range(0, 300) : rnd_word(),
						$urandom_range(0, 1), rnd_word(),
						$urandom_range(0, 4) == 0 ? rnd_word() : $urandom_range(0, 40),
						$urandom));
					n++;
				end
				default: begin
					pending_reqs.push_back(mk(CMD_READ, rnd_word(), $urandom_range(0, 1),
						rnd_word(), rnd_word(),
						$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70)));
					n++;
				end
			endcase
		end

		// drain: stimulus gone, request taken, every response checked
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		wait (!req_ch.valid && expected_rsps.size() == 0);
		repeat (600) @(posedge clk);
		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("piece_table_editor_top verification clean");
		else
			$display("piece_table_editor_top verification failed");
		$finish;
	end
endmodule
